@@ sv/belr_pkg.sv @@
package belr_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int CNT_W       = 8;
	localparam int IDX_W       = 7;
	localparam int LVL_W       = 7;
	localparam int CLS_W       = 5;
	localparam int OVF_W       = 16;
	localparam int VISO_W      = 7;

	localparam logic [OVF_W-1:0]  OVF_MAX  = '1;
	localparam logic [VISO_W-1:0] VISO_MAX = '1;

	// bidi classes that the explicit rules look at
	localparam logic [CLS_W-1:0] C_L   = 5'd0;
	localparam logic [CLS_W-1:0] C_R   = 5'd1;
	localparam logic [CLS_W-1:0] C_BN  = 5'd9;
	localparam logic [CLS_W-1:0] C_B   = 5'd10;
	localparam logic [CLS_W-1:0] C_LRE = 5'd14;
	localparam logic [CLS_W-1:0] C_LRO = 5'd15;
	localparam logic [CLS_W-1:0] C_RLE = 5'd16;
	localparam logic [CLS_W-1:0] C_RLO = 5'd17;
	localparam logic [CLS_W-1:0] C_PDF = 5'd18;
	localparam logic [CLS_W-1:0] C_LRI = 5'd19;
	localparam logic [CLS_W-1:0] C_RLI = 5'd20;
	localparam logic [CLS_W-1:0] C_FSI = 5'd21;
	localparam logic [CLS_W-1:0] C_PDI = 5'd22;

	// override status codes
	localparam logic [1:0] OVR_NONE = 2'd0;
	localparam logic [1:0] OVR_L    = 2'd1;
	localparam logic [1:0] OVR_R    = 2'd2;

	typedef struct packed {
		logic             iso;
		logic [1:0]       ovr;
		logic [LVL_W-1:0] lvl;
	} entry_t;

	typedef struct packed {
		logic accept;
		logic cfg_wr;
		logic exec;
		logic pop_rd;
		logic pop_ld;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic pop_req;
		logic pdi;
		logic cnt_gt1;
		logic top_iso;
	} dp_status_t;

endpackage

@@ sv/belr_ctrl.sv @@
module belr_ctrl import belr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP_RD,
		S_POP_LD,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   was_iso_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cfg_valid) begin
					cmd.cfg_wr = 1'b1;
				end else if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (status.pop_req) begin
					state_d = S_POP_RD;
				end else if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_POP_RD: begin
				if (status.cnt_gt1) begin
					cmd.pop_rd = 1'b1;
					state_d    = S_POP_LD;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_POP_LD: begin
				cmd.pop_ld = 1'b1;
				if (status.pdi && !was_iso_q) begin
					state_d = S_POP_RD;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			was_iso_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.pop_rd) begin
				was_iso_q <= status.top_iso;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a finished request never overwrites a result still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");

	// a pop load always follows its read
	a_pop_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_rd |=> cmd.pop_ld)
		else $error("stack read without load");

	// the bottom entry is never popped
	a_pop_floor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_rd |-> status.cnt_gt1)
		else $error("pop from single-entry stack");

endmodule

@@ sv/belr_dpath.sv @@
module belr_dpath import belr_pkg::*; #(
	parameter int MAX_LEVEL = 125
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_status_t       status,
	input  logic [CLS_W-1:0] char_class,
	input  logic             fsi_rtl,
	input  logic [LVL_W-1:0] cfg_data,
	output logic [LVL_W-1:0] level,
	output logic [CLS_W-1:0] out_class,
	output logic             removed
);

	localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(MAX_LEVEL);

	entry_t mem [STACK_DEPTH];

	logic [LVL_W-1:0]  base_q;
	entry_t            top_q;
	logic [CNT_W-1:0]  count_q;
	logic [OVF_W-1:0]  ovf_iso_q;
	logic [OVF_W-1:0]  ovf_emb_q;
	logic [VISO_W-1:0] viso_q;
	logic [CLS_W-1:0]  cls_q;
	logic              rtl_q;
	entry_t            rd_data_q;
	logic [LVL_W-1:0]  res_level_q;
	logic [CLS_W-1:0]  res_class_q;
	logic              res_removed_q;
	logic [LVL_W-1:0]  level_q;
	logic [CLS_W-1:0]  class_q;
	logic              removed_q;

	logic              is_embed;
	logic              is_iso;
	logic              is_pdf;
	logic              is_pdi;
	logic              rtl_dir;
	logic [LVL_W:0]    odd_lvl;
	logic [LVL_W:0]    even_lvl;
	logic [LVL_W:0]    new_lvl;
	logic              can_push;
	logic [1:0]        new_ovr;
	entry_t            new_entry;
	entry_t            base_entry;
	logic [IDX_W-1:0]  wr_idx;
	logic [IDX_W-1:0]  rd_idx;
	logic [LVL_W-1:0]  cfg_clamped;
	logic [CLS_W-1:0]  ovr_class;
	logic [LVL_W-1:0]  live_level;
	logic [CLS_W-1:0]  live_class;
	logic              live_removed;
	logic              use_live;

	function automatic logic [CLS_W-1:0] apply_ovr(input logic [1:0] ovr,
		input logic [CLS_W-1:0] cls);
		logic [CLS_W-1:0] r;
		r = cls;
		if (ovr == OVR_L) begin
			r = C_L;
		end else if (ovr == OVR_R) begin
			r = C_R;
		end
		return r;
	endfunction

	assign is_embed = cls_q inside {C_LRE, C_LRO, C_RLE, C_RLO};
	assign is_iso   = cls_q inside {C_LRI, C_RLI, C_FSI};
	assign is_pdf   = (cls_q == C_PDF);
	assign is_pdi   = (cls_q == C_PDI);

	assign rtl_dir  = (cls_q inside {C_RLE, C_RLO, C_RLI}) || ((cls_q == C_FSI) && rtl_q);
	assign odd_lvl  = ({1'b0, top_q.lvl} + (LVL_W+1)'(1)) | (LVL_W+1)'(1);
	assign even_lvl = ({1'b0, top_q.lvl} + (LVL_W+1)'(2)) & ~(LVL_W+1)'(1);
	assign new_lvl  = rtl_dir ? odd_lvl : even_lvl;
	assign can_push = (new_lvl <= {1'b0, MAX_LVL}) && (ovf_iso_q == '0)
		&& (ovf_emb_q == '0) && (count_q < CNT_W'(STACK_DEPTH));

	assign new_ovr = (cls_q == C_RLO) ? OVR_R : (cls_q == C_LRO) ? OVR_L : OVR_NONE;
	assign new_entry.iso = is_iso;
	assign new_entry.ovr = is_iso ? OVR_NONE : new_ovr;
	assign new_entry.lvl = new_lvl[LVL_W-1:0];

	assign base_entry.iso = 1'b0;
	assign base_entry.ovr = OVR_NONE;
	assign base_entry.lvl = base_q;

	assign wr_idx      = count_q[IDX_W-1:0];
	assign rd_idx      = IDX_W'(count_q - CNT_W'(2));
	assign cfg_clamped = (cfg_data > MAX_LVL) ? MAX_LVL : cfg_data;
	assign ovr_class   = apply_ovr(top_q.ovr, cls_q);

	// result as seen from the current top of stack
	always_comb begin
		live_level   = top_q.lvl;
		live_class   = cls_q;
		live_removed = 1'b0;
		if (is_embed) begin
			live_removed = 1'b1;
			if (can_push) begin
				live_level = new_lvl[LVL_W-1:0];
			end
		end else if (is_iso || is_pdi) begin
			live_class = ovr_class;
		end else if (is_pdf || (cls_q == C_BN)) begin
			live_removed = 1'b1;
		end else if (cls_q == C_B) begin
			live_level = base_q;
		end else begin
			live_class = ovr_class;
		end
	end

	assign use_live = cmd.exec || is_pdf || is_pdi;

	assign status.pop_req = (is_pdf && (ovf_iso_q == '0) && (ovf_emb_q == '0)
		&& !top_q.iso && (count_q >= CNT_W'(2)))
		|| (is_pdi && (ovf_iso_q == '0) && (viso_q != '0));
	assign status.pdi     = is_pdi;
	assign status.cnt_gt1 = (count_q > CNT_W'(1));
	assign status.top_iso = top_q.iso;

	// stack memory, entry 0 lives in base_q
	always_ff @(posedge clk) begin
		if (cmd.exec && (is_embed || is_iso) && can_push) begin
			mem[wr_idx] <= new_entry;
		end
		if (cmd.pop_rd) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			top_q     <= '0;
			count_q   <= CNT_W'(1);
			ovf_iso_q <= '0;
			ovf_emb_q <= '0;
			viso_q    <= '0;
		end else if (cmd.cfg_wr) begin
			base_q     <= cfg_clamped;
			top_q.iso  <= 1'b0;
			top_q.ovr  <= OVR_NONE;
			top_q.lvl  <= cfg_clamped;
			count_q    <= CNT_W'(1);
			ovf_iso_q  <= '0;
			ovf_emb_q  <= '0;
			viso_q     <= '0;
		end else if (cmd.exec) begin
			if (is_embed) begin
				if (can_push) begin
					top_q   <= new_entry;
					count_q <= count_q + CNT_W'(1);
				end else if ((ovf_iso_q == '0) && (ovf_emb_q != OVF_MAX)) begin
					ovf_emb_q <= ovf_emb_q + OVF_W'(1);
				end
			end else if (is_iso) begin
				if (can_push) begin
					top_q   <= new_entry;
					count_q <= count_q + CNT_W'(1);
					if (viso_q != VISO_MAX) begin
						viso_q <= viso_q + VISO_W'(1);
					end
				end else if (ovf_iso_q != OVF_MAX) begin
					ovf_iso_q <= ovf_iso_q + OVF_W'(1);
				end
			end else if (is_pdi) begin
				if (ovf_iso_q != '0) begin
					ovf_iso_q <= ovf_iso_q - OVF_W'(1);
				end else if (viso_q != '0) begin
					ovf_emb_q <= '0;
					viso_q    <= viso_q - VISO_W'(1);
				end
			end else if (is_pdf) begin
				if ((ovf_iso_q == '0) && (ovf_emb_q != '0)) begin
					ovf_emb_q <= ovf_emb_q - OVF_W'(1);
				end
			end else if (cls_q == C_B) begin
				top_q     <= base_entry;
				count_q   <= CNT_W'(1);
				ovf_iso_q <= '0;
				ovf_emb_q <= '0;
				viso_q    <= '0;
			end
		end else if (cmd.pop_ld) begin
			top_q   <= (count_q == CNT_W'(2)) ? base_entry : rd_data_q;
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cls_q <= char_class;
			rtl_q <= fsi_rtl;
		end
		if (cmd.exec) begin
			res_level_q   <= live_level;
			res_class_q   <= live_class;
			res_removed_q <= live_removed;
		end
		if (cmd.load_out) begin
			level_q   <= use_live ? live_level : res_level_q;
			class_q   <= use_live ? live_class : res_class_q;
			removed_q <= use_live ? live_removed : res_removed_q;
		end
	end

	assign level     = level_q;
	assign out_class = class_q;
	assign removed   = removed_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= CNT_W'(STACK_DEPTH)))
		else $error("stack count out of range");

	a_top_level: assert property (@(posedge clk) disable iff (!arst_n)
		top_q.lvl <= MAX_LVL)
		else $error("top level above limit");

	a_push_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && (is_embed || is_iso) && can_push) |-> (wr_idx != '0))
		else $error("push onto base entry slot");

endmodule

@@ sv/bidi_explicit_level_resolver_core.sv @@
// explicit embedding level resolver (bidi rules X1 to X9): one request carries a
// character's bidi class, plus the first-strong direction for FSI, and yields its
// explicit level, its class after any directional override and a removal flag.
// the directional status stack sits in a 128-entry memory with the top entry held
// in registers, so pushes and plain characters take an accept step, then an execute
// step, with the result registered at the end of execute. each stack pop adds a
// memory read, then a top reload, and the result then loads in a finish step: a PDF
// that pops passes accept, execute, read, reload and finish, and a PDI that closes
// an isolate repeats read and reload for each entry it pops. a result register sits
// on the output, so the next request is taken while a result waits; a stalled
// output holds the block only when a second result is ready. writing base_level
// (clamped to MAX_LEVEL) restarts the paragraph at once; no clearing pass is needed
module bidi_explicit_level_resolver_core import belr_pkg::*; #(
	parameter int MAX_LEVEL = 125
) (
	input  logic             clk,
	input  logic             arst_n,
	// configuration write channel
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [LVL_W-1:0] cfg_data,
	// input request channel
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CLS_W-1:0] char_class,
	input  logic             fsi_rtl,
	// result channel
	output logic             out_valid,
	input  logic             out_ready,
	output logic [LVL_W-1:0] level,
	output logic [CLS_W-1:0] out_class,
	output logic             removed
);

	// commands from the sequencer, status back from the stack datapath
	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencer: request acceptance, pop loop, result handoff
	belr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// stack, counters and result register
	belr_dpath #(
		.MAX_LEVEL (MAX_LEVEL)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.char_class (char_class),
		.fsi_rtl    (fsi_rtl),
		.cfg_data   (cfg_data),
		.level      (level),
		.out_class  (out_class),
		.removed    (removed)
	);

endmodule
